// File: design/tsrlc_pkg.sv
// Shared constants, tables, functions and handshake structs for the thermal sensor level control.
// Used by tsrlc_ctrl, tsrlc_dp and the top level; depends on nothing else.
package tsrlc_pkg;

  localparam int TABLE_ENTRIES = 33;
  localparam int ADC_BITS      = 12;
  localparam int MAX_SAMPLES   = 64;

  localparam int SUM_W      = 18;
  localparam int SPR_W      = 7;
  localparam int RMV_W      = 12;
  localparam int TEMP_W     = 9;
  localparam int MV_W       = 16;
  localparam int VCO_W      = 4;
  localparam int BT_W       = 5;
  localparam int PLL_W      = 2;
  localparam int WORD_W     = 21;
  localparam int ROM_W      = 10;
  localparam int CODE_W     = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam int PROD_W     = RMV_W + SUM_W;
  localparam int DIV_CNT_W  = $clog2(PROD_W);
  localparam int ROM_IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int WALK_W     = $clog2(TABLE_ENTRIES + 1);

  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam int T_LOW  = -30;
  localparam int T_STEP = 5;

  localparam logic [VCO_W-1:0] BOOST_VCO = VCO_W'(5);
  localparam logic [BT_W-1:0]  BOOST_BT  = BT_W'(10);

  localparam logic [SPR_W-1:0] SPR_RESET  = SPR_W'(8);
  localparam logic [RMV_W-1:0] RMV_RESET  = RMV_W'(1200);

  localparam logic [PLL_W-1:0] PLL_L0 = PLL_W'(0);
  localparam logic [PLL_W-1:0] PLL_L1 = PLL_W'(1);
  localparam logic [PLL_W-1:0] PLL_L2 = PLL_W'(2);

  localparam logic [WORD_W-1:0] PLL_WORD_L0 = WORD_W'(1398101);
  localparam logic [WORD_W-1:0] PLL_WORD_L1 = WORD_W'(1390000);
  localparam logic [WORD_W-1:0] PLL_WORD_L2 = WORD_W'(1330000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLES    = 3'd0,
    CFG_REF_MV     = 3'd1,
    CFG_BOOST_ON   = 3'd2,
    CFG_BOOST_OFF  = 3'd3,
    CFG_PLL_UP1    = 3'd4,
    CFG_PLL_DOWN1  = 3'd5,
    CFG_PLL_UP2    = 3'd6,
    CFG_PLL_DOWN2  = 3'd7
  } cfg_reg_t;

  // Sensor voltage in mV at -30 C .. 130 C, 5 C apart
  localparam logic [ROM_W-1:0] VOLT_ROM [TABLE_ENTRIES] = '{
    10'd384, 10'd392, 10'd403, 10'd411, 10'd418, 10'd424, 10'd434, 10'd443,
    10'd450, 10'd459, 10'd469, 10'd476, 10'd483, 10'd491, 10'd500, 10'd509,
    10'd516, 10'd524, 10'd531, 10'd540, 10'd547, 10'd556, 10'd566, 10'd576,
    10'd583, 10'd595, 10'd602, 10'd611, 10'd618, 10'd628, 10'd634, 10'd643,
    10'd651
  };

  function automatic logic [ROM_W-1:0] rom_at(input logic [ROM_IDX_W-1:0] i);
    logic [ROM_W-1:0] v;
    v = '0;
    if (32'(i) < TABLE_ENTRIES) begin
      v = VOLT_ROM[i];
    end
    return v;
  endfunction

  function automatic logic [WORD_W-1:0] pll_word_of(input logic [PLL_W-1:0] lvl);
    logic [WORD_W-1:0] w;
    case (lvl)
      PLL_L0:  w = PLL_WORD_L0;
      PLL_L1:  w = PLL_WORD_L1;
      PLL_L2:  w = PLL_WORD_L2;
      default: w = '0;
    endcase
    return w;
  endfunction

  typedef struct packed {
    logic accept;
    logic start_mul;
    logic div_step;
    logic walk_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic last_item;
    logic div_last;
    logic walk_done;
  } status_t;

endpackage

// File: design/thermal_sensor_rf_level_control_unit.sv
// Top level of the thermal sensor level control: sequencer plus datapath, and checks.
// Depends on tsrlc_pkg, tsrlc_ctrl and tsrlc_dp.
//
// Usage: each transfer on the in_ channel carries one sensor/reference code pair and the
// present vco and bt supply settings. Items are summed; the item that completes a batch of
// samples_per_result pairs starts the result computation, other items give no result and
// are taken one per cycle while in_stall is low. A completed batch gives one out_ transfer
// carrying millivolts, temperature, boost and PLL decisions.
// After the last item the sequencer runs the multiply step, the restoring divider (one quotient
// bit per cycle), the ROM walk (one entry per cycle) and the decision step; in_stall is high
// throughout, so no new item is taken until the result is loaded.
// The result sits in an output register: while out_stall holds it, new items are taken again
// and the next batch waits in the decision step until the register frees up. Writes on cfg_ are
// always ready; the user must make them only while the block is idle (the block does not check).
// Reset (rst_n low, synchronous) restores the register defaults, clears the sums, the boost
// and PLL levels and the saved supply settings, and drops any pending result.
module thermal_sensor_rf_level_control_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tsrlc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tsrlc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [tsrlc_pkg::CODE_W-1:0]         in_sensor_code,
  input  logic [tsrlc_pkg::CODE_W-1:0]         in_reference_code,
  input  logic [tsrlc_pkg::VCO_W-1:0]          in_present_vco,
  input  logic [tsrlc_pkg::BT_W-1:0]           in_present_bt,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [tsrlc_pkg::MV_W-1:0]           out_sensor_mv,
  output logic signed [tsrlc_pkg::TEMP_W-1:0]  out_temperature_c,
  output logic                                 out_boost_active,
  output logic                                 out_supply_update,
  output logic [tsrlc_pkg::VCO_W-1:0]          out_vco_setting,
  output logic [tsrlc_pkg::BT_W-1:0]           out_bt_setting,
  output logic [tsrlc_pkg::PLL_W-1:0]          out_pll_band,
  output logic                                 out_pll_update,
  output logic [tsrlc_pkg::WORD_W-1:0]         out_pll_word
);

  tsrlc_pkg::cmd_t    cmd;
  tsrlc_pkg::status_t status;

  assign cfg_ready = 1'b1;

  tsrlc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tsrlc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_sensor_code    (in_sensor_code),
    .in_reference_code (in_reference_code),
    .in_present_vco    (in_present_vco),
    .in_present_bt     (in_present_bt),
    .cmd               (cmd),
    .status            (status),
    .out_sensor_mv     (out_sensor_mv),
    .out_temperature_c (out_temperature_c),
    .out_boost_active  (out_boost_active),
    .out_supply_update (out_supply_update),
    .out_vco_setting   (out_vco_setting),
    .out_bt_setting    (out_bt_setting),
    .out_pll_band      (out_pll_band),
    .out_pll_update    (out_pll_update),
    .out_pll_word      (out_pll_word)
  );

  a_pll_band_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pll_band == tsrlc_pkg::PLL_L0 ||
                   out_pll_band == tsrlc_pkg::PLL_L1 ||
                   out_pll_band == tsrlc_pkg::PLL_L2))
    else $error("pll band out of range");

  a_pll_word_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pll_word == tsrlc_pkg::pll_word_of(out_pll_band)))
    else $error("pll word does not match band");

  a_boost_engage: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_supply_update && out_boost_active) |->
      (out_vco_setting == tsrlc_pkg::BOOST_VCO && out_bt_setting == tsrlc_pkg::BOOST_BT))
    else $error("boost engage settings wrong");

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_mul |=> in_stall)
    else $error("input taken while divider busy");

endmodule

// File: design/tsrlc_ctrl.sv
// Sequencer for the thermal sensor level control: accumulate, multiply, divide, table walk, decide.
// Depends on tsrlc_pkg; drives tsrlc_dp through cmd_t and reads status_t.
module tsrlc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  tsrlc_pkg::status_t status,
  output tsrlc_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_WALK,
    S_DECIDE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    // drop the result once transferred
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.last_item) begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.start_mul = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (status.walk_done) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        // hold until the output register is free or being drained
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: design/tsrlc_dp.sv
// Datapath of the thermal sensor level control: config registers, sums, multiplier,
// restoring divider, ROM walk, hysteresis machines and output register. Depends on tsrlc_pkg.
module tsrlc_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  input  logic [tsrlc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tsrlc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [tsrlc_pkg::CODE_W-1:0]         in_sensor_code,
  input  logic [tsrlc_pkg::CODE_W-1:0]         in_reference_code,
  input  logic [tsrlc_pkg::VCO_W-1:0]          in_present_vco,
  input  logic [tsrlc_pkg::BT_W-1:0]           in_present_bt,
  input  tsrlc_pkg::cmd_t                      cmd,
  output tsrlc_pkg::status_t                   status,
  output logic [tsrlc_pkg::MV_W-1:0]           out_sensor_mv,
  output logic signed [tsrlc_pkg::TEMP_W-1:0]  out_temperature_c,
  output logic                                 out_boost_active,
  output logic                                 out_supply_update,
  output logic [tsrlc_pkg::VCO_W-1:0]          out_vco_setting,
  output logic [tsrlc_pkg::BT_W-1:0]           out_bt_setting,
  output logic [tsrlc_pkg::PLL_W-1:0]          out_pll_band,
  output logic                                 out_pll_update,
  output logic [tsrlc_pkg::WORD_W-1:0]         out_pll_word
);

  // configuration
  logic [tsrlc_pkg::SPR_W-1:0]         spr_r;
  logic [tsrlc_pkg::RMV_W-1:0]         rmv_r;
  logic signed [tsrlc_pkg::TEMP_W-1:0] boost_on_r, boost_off_r;
  logic signed [tsrlc_pkg::TEMP_W-1:0] up1_r, down1_r, up2_r, down2_r;

  // control state
  logic [tsrlc_pkg::SUM_W-1:0]  ssum_r, ssum_nxt, rsum_r, rsum_nxt;
  logic [tsrlc_pkg::SPR_W-1:0]  left_r, reload;
  logic                         boost_r, boost_nxt;
  logic [tsrlc_pkg::PLL_W-1:0]  pll_r, pll_nxt;
  logic [tsrlc_pkg::VCO_W-1:0]  saved_vco_r, vco_nxt;
  logic [tsrlc_pkg::BT_W-1:0]   saved_bt_r, bt_nxt;
  logic                         sup_upd, pll_upd;

  // working registers
  logic [tsrlc_pkg::VCO_W-1:0]     last_vco_r;
  logic [tsrlc_pkg::BT_W-1:0]      last_bt_r;
  logic [tsrlc_pkg::PROD_W-1:0]    quo_r;
  logic [tsrlc_pkg::SUM_W-1:0]     div_d_r, rem_r, rem_nxt;
  logic [tsrlc_pkg::SUM_W:0]       rem_sh;
  logic                            q_bit;
  logic [tsrlc_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic [tsrlc_pkg::WALK_W-1:0]    walk_r;
  logic signed [tsrlc_pkg::TEMP_W-1:0] temp_r, temp_nxt;

  logic [tsrlc_pkg::SUM_W:0]   ssum_add, rsum_add;
  logic [tsrlc_pkg::MV_W-1:0]  mv;
  logic [tsrlc_pkg::ROM_W-1:0] rom_cur, rom_prev;
  logic                        in_range, advance;
  logic [tsrlc_pkg::WALK_W-1:0] walk_prev, idx;
  logic [tsrlc_pkg::MV_W-1:0]   diff_lo, diff_hi;
  logic [tsrlc_pkg::TEMP_W-1:0] temp_bits;

  // reload count: zero counts as one, clamp at the maximum batch size
  always_comb begin
    reload = spr_r;
    if (spr_r == '0) begin
      reload = tsrlc_pkg::SPR_W'(1);
    end else if (32'(spr_r) > tsrlc_pkg::MAX_SAMPLES) begin
      reload = tsrlc_pkg::SPR_W'(tsrlc_pkg::MAX_SAMPLES);
    end
  end

  // saturating accumulate
  always_comb begin
    ssum_add = {1'b0, ssum_r}
             + (tsrlc_pkg::SUM_W+1)'(in_sensor_code[tsrlc_pkg::ADC_BITS-1:0]);
    rsum_add = {1'b0, rsum_r}
             + (tsrlc_pkg::SUM_W+1)'(in_reference_code[tsrlc_pkg::ADC_BITS-1:0]);
    ssum_nxt = ssum_add[tsrlc_pkg::SUM_W] ? tsrlc_pkg::SUM_MAX
                                          : ssum_add[tsrlc_pkg::SUM_W-1:0];
    rsum_nxt = rsum_add[tsrlc_pkg::SUM_W] ? tsrlc_pkg::SUM_MAX
                                          : rsum_add[tsrlc_pkg::SUM_W-1:0];
  end

  // one restoring division step
  always_comb begin
    rem_sh  = {rem_r, quo_r[tsrlc_pkg::PROD_W-1]};
    q_bit   = (rem_sh >= {1'b0, div_d_r});
    rem_nxt = q_bit ? tsrlc_pkg::SUM_W'(rem_sh - {1'b0, div_d_r})
                    : rem_sh[tsrlc_pkg::SUM_W-1:0];
  end

  // saturate on zero divisor or a quotient above 16 bits
  assign mv = ((div_d_r == '0) || (|quo_r[tsrlc_pkg::PROD_W-1:tsrlc_pkg::MV_W]))
            ? '1 : quo_r[tsrlc_pkg::MV_W-1:0];

  // table walk: advance while mv is at or above the current entry
  always_comb begin
    walk_prev = walk_r - tsrlc_pkg::WALK_W'(1);
    rom_cur   = tsrlc_pkg::rom_at(walk_r[tsrlc_pkg::ROM_IDX_W-1:0]);
    rom_prev  = tsrlc_pkg::rom_at(walk_prev[tsrlc_pkg::ROM_IDX_W-1:0]);
    in_range  = (32'(walk_r) < tsrlc_pkg::TABLE_ENTRIES);
    advance   = in_range && (mv >= tsrlc_pkg::MV_W'(rom_cur));
    diff_lo   = mv - tsrlc_pkg::MV_W'(rom_prev);
    diff_hi   = tsrlc_pkg::MV_W'(rom_cur) - mv;
    if (walk_r == '0) begin
      idx = '0;
    end else if (!in_range) begin
      idx = tsrlc_pkg::WALK_W'(tsrlc_pkg::TABLE_ENTRIES - 1);
    end else if (diff_lo < diff_hi) begin
      idx = walk_prev;
    end else begin
      // tie goes to the higher temperature
      idx = walk_r;
    end
    temp_bits = tsrlc_pkg::TEMP_W'(tsrlc_pkg::T_LOW)
              + tsrlc_pkg::TEMP_W'(idx) * tsrlc_pkg::TEMP_W'(tsrlc_pkg::T_STEP);
    temp_nxt  = signed'(temp_bits);
  end

  assign status.last_item = (left_r <= tsrlc_pkg::SPR_W'(1));
  assign status.div_last  = (div_cnt_r == tsrlc_pkg::DIV_CNT_W'(tsrlc_pkg::PROD_W - 1));
  assign status.walk_done = !advance;

  // hysteresis machines
  always_comb begin
    boost_nxt = boost_r;
    vco_nxt   = '0;
    bt_nxt    = '0;
    sup_upd   = 1'b0;
    if (!boost_r && (temp_r >= boost_on_r)) begin
      boost_nxt = 1'b1;
      sup_upd   = 1'b1;
      vco_nxt   = tsrlc_pkg::BOOST_VCO;
      bt_nxt    = tsrlc_pkg::BOOST_BT;
    end else if (boost_r && (temp_r <= boost_off_r)) begin
      boost_nxt = 1'b0;
      sup_upd   = 1'b1;
      vco_nxt   = saved_vco_r;
      bt_nxt    = saved_bt_r;
    end

    pll_nxt = pll_r;
    pll_upd = 1'b0;
    case (pll_r)
      tsrlc_pkg::PLL_L0: begin
        if (temp_r >= up1_r) begin
          pll_nxt = tsrlc_pkg::PLL_L1;
          pll_upd = 1'b1;
        end
      end
      tsrlc_pkg::PLL_L1: begin
        if (temp_r >= up2_r) begin
          pll_nxt = tsrlc_pkg::PLL_L2;
          pll_upd = 1'b1;
        end else if (temp_r <= down1_r) begin
          pll_nxt = tsrlc_pkg::PLL_L0;
          pll_upd = 1'b1;
        end
      end
      tsrlc_pkg::PLL_L2: begin
        if (temp_r <= down2_r) begin
          pll_nxt = tsrlc_pkg::PLL_L1;
          pll_upd = 1'b1;
        end
      end
      default: begin
        pll_nxt = pll_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spr_r       <= tsrlc_pkg::SPR_RESET;
      rmv_r       <= tsrlc_pkg::RMV_RESET;
      boost_on_r  <= tsrlc_pkg::TEMP_W'(60);
      boost_off_r <= tsrlc_pkg::TEMP_W'(40);
      up1_r       <= tsrlc_pkg::TEMP_W'(80);
      down1_r     <= tsrlc_pkg::TEMP_W'(70);
      up2_r       <= tsrlc_pkg::TEMP_W'(110);
      down2_r     <= tsrlc_pkg::TEMP_W'(100);
      ssum_r      <= '0;
      rsum_r      <= '0;
      left_r      <= tsrlc_pkg::SPR_RESET;
      boost_r     <= 1'b0;
      pll_r       <= tsrlc_pkg::PLL_L0;
      saved_vco_r <= '0;
      saved_bt_r  <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          tsrlc_pkg::CFG_SAMPLES:   spr_r       <= cfg_wdata[tsrlc_pkg::SPR_W-1:0];
          tsrlc_pkg::CFG_REF_MV:    rmv_r       <= cfg_wdata[tsrlc_pkg::RMV_W-1:0];
          tsrlc_pkg::CFG_BOOST_ON:  boost_on_r  <= signed'(cfg_wdata[tsrlc_pkg::TEMP_W-1:0]);
          tsrlc_pkg::CFG_BOOST_OFF: boost_off_r <= signed'(cfg_wdata[tsrlc_pkg::TEMP_W-1:0]);
          tsrlc_pkg::CFG_PLL_UP1:   up1_r       <= signed'(cfg_wdata[tsrlc_pkg::TEMP_W-1:0]);
          tsrlc_pkg::CFG_PLL_DOWN1: down1_r     <= signed'(cfg_wdata[tsrlc_pkg::TEMP_W-1:0]);
          tsrlc_pkg::CFG_PLL_UP2:   up2_r       <= signed'(cfg_wdata[tsrlc_pkg::TEMP_W-1:0]);
          tsrlc_pkg::CFG_PLL_DOWN2: down2_r     <= signed'(cfg_wdata[tsrlc_pkg::TEMP_W-1:0]);
          default: begin
          end
        endcase
      end
      if (cmd.accept) begin
        ssum_r <= ssum_nxt;
        rsum_r <= rsum_nxt;
        // reload on the last item of a batch, count down otherwise
        left_r <= status.last_item ? reload : left_r - tsrlc_pkg::SPR_W'(1);
      end
      if (cmd.start_mul) begin
        ssum_r <= '0;
        rsum_r <= '0;
      end
      if (cmd.load_out) begin
        boost_r <= boost_nxt;
        pll_r   <= pll_nxt;
        if (!boost_r && boost_nxt) begin
          saved_vco_r <= last_vco_r;
          saved_bt_r  <= last_bt_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      last_vco_r <= in_present_vco;
      last_bt_r  <= in_present_bt;
    end
    if (cmd.start_mul) begin
      quo_r     <= tsrlc_pkg::PROD_W'(rmv_r) * tsrlc_pkg::PROD_W'(ssum_r);
      div_d_r   <= rsum_r;
      rem_r     <= '0;
      div_cnt_r <= '0;
      walk_r    <= '0;
    end
    if (cmd.div_step) begin
      quo_r     <= {quo_r[tsrlc_pkg::PROD_W-2:0], q_bit};
      rem_r     <= rem_nxt;
      div_cnt_r <= div_cnt_r + tsrlc_pkg::DIV_CNT_W'(1);
    end
    if (cmd.walk_step) begin
      if (advance) begin
        walk_r <= walk_r + tsrlc_pkg::WALK_W'(1);
      end else begin
        temp_r <= temp_nxt;
      end
    end
    if (cmd.load_out) begin
      out_sensor_mv     <= mv;
      out_temperature_c <= temp_r;
      out_boost_active  <= boost_nxt;
      out_supply_update <= sup_upd;
      out_vco_setting   <= vco_nxt;
      out_bt_setting    <= bt_nxt;
      out_pll_band      <= pll_nxt;
      out_pll_update    <= pll_upd;
      out_pll_word      <= tsrlc_pkg::pll_word_of(pll_nxt);
    end
  end

endmodule
